[src/tccw_pkg.sv]
// ---------------------------------------------------------------------------
// tccw_pkg
// Shared widths, codes and types of the text console cell writer.
// ---------------------------------------------------------------------------
package tccw_pkg;

   localparam int MAX_COLUMNS = 80;
   localparam int MAX_ROWS    = 25;
   localparam int TAB_STOP    = 4;

   localparam int DEPTH   = MAX_COLUMNS * MAX_ROWS;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int PROD_W  = COL_W + ROW_W;
   localparam int CHAR_W  = 8;
   localparam int ATTR_W  = 8;
   localparam int CELL_W  = ATTR_W + CHAR_W;
   localparam int INDEX_W = 11;
   localparam int TAB_W   = $clog2(TAB_STOP + 1);
   localparam int CSR_W   = 8;

   localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
   localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
   localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

   localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd9;
   localparam logic [COL_W-1:0]  COLS_RESET = 7'd80;
   localparam logic [ROW_W-1:0]  ROWS_RESET = 5'd25;

   localparam logic MODE_PUT  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef enum logic [1:0] {
      CSR_ATTR = 2'd0,
      CSR_COLS = 2'd1,
      CSR_ROWS = 2'd2
   } tccw_csr_type;

   typedef enum logic [2:0] {
      OP_READ,
      OP_NEWLINE,
      OP_RETURN,
      OP_TAB,
      OP_PLAIN
   } tccw_op_type;

   typedef struct packed {
      tccw_op_type         op;
      logic [CHAR_W-1:0]   char_code;
      logic [INDEX_W-1:0]  cell_index;
   } tccw_cmd_type;

   typedef struct packed {
      logic [ATTR_W-1:0] attribute;
      logic [COL_W-1:0]  width;
      logic [ROW_W-1:0]  height;
   } tccw_cfg_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PUT,
      ST_FILL,
      ST_COPY,
      ST_BLANK
   } tccw_state_type;

endpackage

[src/tccw_channels.sv]
// ---------------------------------------------------------------------------
// tccw channels
// Request, response and register write channels of the console writer.
// ---------------------------------------------------------------------------
interface tccw_req_if;
   import tccw_pkg::*;
   logic                valid;
   logic                ready;
   logic                mode;
   logic [CHAR_W-1:0]   char_code;
   logic [INDEX_W-1:0]  cell_index;
   modport source (output valid, mode, char_code, cell_index, input ready);
   modport sink   (input valid, mode, char_code, cell_index, output ready);
endinterface

interface tccw_rsp_if;
   import tccw_pkg::*;
   logic               valid;
   logic               ready;
   logic [CELL_W-1:0]  cell_data;
   logic [COL_W-1:0]   column_now;
   logic [ROW_W-1:0]   row_now;
   modport source (output valid, cell_data, column_now, row_now, input ready);
   modport sink   (input valid, cell_data, column_now, row_now, output ready);
endinterface

interface tccw_csr_if;
   import tccw_pkg::*;
   logic              valid;
   logic              ready;
   logic [1:0]        reg_index;
   logic [CSR_W-1:0]  write_data;
   modport source (output valid, reg_index, write_data, input ready);
   modport sink   (input valid, reg_index, write_data, output ready);
endinterface

[src/tccw_csr.sv]
// ---------------------------------------------------------------------------
// tccw_csr
// Configuration registers and the clamped screen geometry derived from them.
// ---------------------------------------------------------------------------
module tccw_csr (
   input  logic                  clock,
   input  logic                  reset,
   tccw_csr_if.sink              csr_ch,
   output tccw_pkg::tccw_cfg_type cfg
);
   import tccw_pkg::*;

   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic [COL_W-1:0]  cols_ff, cols_in;
   logic [ROW_W-1:0]  rows_ff, rows_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      attr_in = attr_ff;
      cols_in = cols_ff;
      rows_in = rows_ff;
      if (csr_ch.valid) begin
         unique case (csr_ch.reg_index)
            CSR_ATTR: attr_in = csr_ch.write_data[ATTR_W-1:0];
            CSR_COLS: cols_in = csr_ch.write_data[COL_W-1:0];
            CSR_ROWS: rows_in = csr_ch.write_data[ROW_W-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= ATTR_RESET;
         cols_ff <= COLS_RESET;
         rows_ff <= ROWS_RESET;
      end else begin
         attr_ff <= attr_in;
         cols_ff <= cols_in;
         rows_ff <= rows_in;
      end
   end

   // zero reads as one, too large saturates
   always_comb begin
      cfg.attribute = attr_ff;
      if (cols_ff == '0)
         cfg.width = COL_W'(1);
      else if (cols_ff > COL_W'(MAX_COLUMNS))
         cfg.width = COL_W'(MAX_COLUMNS);
      else
         cfg.width = cols_ff;
      if (rows_ff == '0)
         cfg.height = ROW_W'(1);
      else if (rows_ff > ROW_W'(MAX_ROWS))
         cfg.height = ROW_W'(MAX_ROWS);
      else
         cfg.height = rows_ff;
   end

endmodule

[src/tccw_front.sv]
// ---------------------------------------------------------------------------
// tccw_front
// Accepts requests, classifies them into commands and queues them for the
// back end.
// ---------------------------------------------------------------------------
module tccw_front (
   input  logic                   clock,
   input  logic                   reset,
   tccw_req_if.sink               req_ch,
   input  logic                   clear_busy,
   output logic                   cmd_valid,
   output tccw_pkg::tccw_cmd_type cmd,
   input  logic                   cmd_pop
);
   import tccw_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   tccw_cmd_type       slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   tccw_cmd_type       class_cmd;
   logic               push;
   logic               pop;

   assign req_ch.ready = !clear_busy && (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;
   assign cmd_valid    = (count_ff != '0);
   assign pop          = cmd_pop && cmd_valid;
   assign cmd          = slot_ff[rd_ptr_ff];

   always_comb begin
      class_cmd.char_code  = req_ch.char_code;
      class_cmd.cell_index = req_ch.cell_index;
      if (req_ch.mode == MODE_READ)
         class_cmd.op = OP_READ;
      else if (req_ch.char_code == CH_NEWLINE)
         class_cmd.op = OP_NEWLINE;
      else if (req_ch.char_code == CH_RETURN)
         class_cmd.op = OP_RETURN;
      else if (req_ch.char_code == CH_TAB)
         class_cmd.op = OP_TAB;
      else
         class_cmd.op = OP_PLAIN;
   end

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop)
         count_in = count_ff + QCNT_W'(1);
      else if (pop && !push)
         count_in = count_ff - QCNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= class_cmd;
   end

endmodule

[src/tccw_back.sv]
// ---------------------------------------------------------------------------
// tccw_back
// Command sequencer: owns the screen memory and the cursor, runs the clear
// pass, cell reads and writes, row fills and scrolls, and drives the response register.
// ---------------------------------------------------------------------------
module tccw_back (
   input  logic                   clock,
   input  logic                   reset,
   input  tccw_pkg::tccw_cfg_type cfg,
   input  logic                   cmd_valid,
   input  tccw_pkg::tccw_cmd_type cmd,
   output logic                   cmd_pop,
   output logic                   clear_busy,
   tccw_rsp_if.source             rsp_ch
);
   import tccw_pkg::*;

   tccw_state_type     state_ff, state_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [ADDR_W-1:0]  scan_ff, scan_in;
   logic [TAB_W-1:0]   tab_ff, tab_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               nl_put_ff, nl_put_in;
   logic               pend_ff, pend_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic               rd_zero_ff, rd_zero_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0]  rsp_data_ff;
   logic [COL_W-1:0]   rsp_col_ff;
   logic [ROW_W-1:0]   rsp_row_ff;

   logic [CELL_W-1:0]  mem [DEPTH];
   logic [CELL_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_waddr;
   logic [CELL_W-1:0]  mem_wdata;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;

   logic               emit;
   logic [CELL_W-1:0]  emit_data;
   logic               slot_free;
   logic               dispatch;
   logic               col_ge_w;
   logic               row_on_screen;
   logic               nl_wrap;
   logic               idx_in_range;
   logic               scan_at_end;
   logic               blank_last;
   logic [PROD_W-1:0]  row_base;
   logic [PROD_W-1:0]  addr_wide;
   logic [PROD_W-1:0]  cells_wide;
   logic [ADDR_W-1:0]  cur_addr;
   logic [ADDR_W-1:0]  last_base;
   logic [TAB_W-1:0]   tab_amount;

   // ---- geometry and status
   assign row_base      = PROD_W'(row_ff) * PROD_W'(cfg.width);
   assign addr_wide     = row_base + PROD_W'(col_ff);
   assign cur_addr      = addr_wide[ADDR_W-1:0];
   assign cells_wide    = PROD_W'(cfg.height) * PROD_W'(cfg.width);
   assign last_base     = cells_wide[ADDR_W-1:0] - ADDR_W'(cfg.width);
   assign col_ge_w      = (col_ff >= cfg.width);
   assign row_on_screen = (row_ff < cfg.height);
   assign nl_wrap       = ({1'b0, row_ff} + (ROW_W+1)'(1)) >= {1'b0, cfg.height};
   assign idx_in_range  = (cmd.cell_index < INDEX_W'(DEPTH));
   assign scan_at_end   = (PROD_W'(scan_ff) >= cells_wide);
   assign blank_last    = (PROD_W'(scan_ff) == cells_wide - PROD_W'(1));
   assign tab_amount    = TAB_W'(TAB_STOP) - TAB_W'(col_ff % COL_W'(TAB_STOP));
   assign slot_free     = !rsp_valid_ff || rsp_ch.ready;
   assign dispatch      = (state_ff == ST_IDLE) && cmd_valid && slot_free;
   assign clear_busy    = (state_ff == ST_CLEAR);

   // ---- next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (scan_ff == ADDR_W'(DEPTH - 1))
               state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (dispatch) begin
               unique case (cmd.op)
                  OP_READ:    state_in = ST_READ;
                  OP_RETURN:  state_in = ST_IDLE;
                  OP_NEWLINE: state_in = ST_FILL;
                  OP_TAB:     state_in = ST_PUT;
                  OP_PLAIN:   state_in = ST_PUT;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_PUT: begin
            if (col_ge_w)
               state_in = ST_FILL;
            else if (tab_ff == TAB_W'(1))
               state_in = ST_IDLE;
         end
         ST_FILL: begin
            if (col_ge_w) begin
               if (nl_wrap)
                  state_in = ST_COPY;
               else
                  state_in = nl_put_ff ? ST_PUT : ST_IDLE;
            end
         end
         ST_COPY: begin
            if (scan_at_end)
               state_in = ST_BLANK;
         end
         ST_BLANK: begin
            if (blank_last)
               state_in = nl_put_ff ? ST_PUT : ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // ---- datapath and memory controls
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      scan_in      = scan_ff;
      tab_in       = tab_ff;
      char_in      = char_ff;
      nl_put_in    = nl_put_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      rd_zero_in   = rd_zero_ff;
      mem_we       = 1'b0;
      mem_waddr    = '0;
      mem_wdata    = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;
      emit         = 1'b0;
      emit_data    = '0;
      cmd_pop      = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            scan_in   = scan_ff + ADDR_W'(1);
         end
         ST_IDLE: begin
            if (dispatch) begin
               cmd_pop = 1'b1;
               unique case (cmd.op)
                  OP_READ: begin
                     rd_en      = idx_in_range;
                     rd_addr    = cmd.cell_index[ADDR_W-1:0];
                     rd_zero_in = !idx_in_range;
                  end
                  OP_RETURN: begin
                     col_in = '0;
                     emit   = 1'b1;
                  end
                  OP_NEWLINE: nl_put_in = 1'b0;
                  OP_TAB: begin
                     char_in   = CH_SPACE;
                     tab_in    = tab_amount;
                     nl_put_in = 1'b1;
                  end
                  OP_PLAIN: begin
                     char_in   = cmd.char_code;
                     tab_in    = TAB_W'(1);
                     nl_put_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end
         ST_READ: begin
            emit      = 1'b1;
            emit_data = rd_zero_ff ? '0 : rd_data_ff;
         end
         ST_PUT: begin
            // a full row wraps through the newline states first
            if (!col_ge_w) begin
               if (row_on_screen) begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr;
                  mem_wdata = {cfg.attribute, char_ff};
                  col_in    = col_ff + COL_W'(1);
               end
               tab_in = tab_ff - TAB_W'(1);
               emit   = (tab_ff == TAB_W'(1));
            end
         end
         ST_FILL: begin
            if (!col_ge_w) begin
               if (row_on_screen) begin
                  mem_we    = 1'b1;
                  mem_waddr = cur_addr;
                  mem_wdata = {cfg.attribute, CH_SPACE};
               end
               col_in = col_ff + COL_W'(1);
            end else begin
               col_in = '0;
               if (nl_wrap) begin
                  row_in  = cfg.height - ROW_W'(1);
                  scan_in = ADDR_W'(cfg.width);
               end else begin
                  row_in = row_ff + ROW_W'(1);
                  emit   = !nl_put_ff;
               end
            end
         end
         ST_COPY: begin
            // read one row ahead, write the cell one row up in the following cycle
            if (pend_ff) begin
               mem_we    = 1'b1;
               mem_waddr = pend_addr_ff;
               mem_wdata = rd_data_ff;
            end
            if (!scan_at_end) begin
               rd_en        = 1'b1;
               rd_addr      = scan_ff;
               pend_in      = 1'b1;
               pend_addr_in = scan_ff - ADDR_W'(cfg.width);
               scan_in      = scan_ff + ADDR_W'(1);
            end else begin
               scan_in = last_base;
            end
         end
         ST_BLANK: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff;
            mem_wdata = {cfg.attribute, CH_SPACE};
            scan_in   = scan_ff + ADDR_W'(1);
            emit      = blank_last && !nl_put_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         scan_ff      <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tab_ff       <= tab_in;
      char_ff      <= char_in;
      nl_put_ff    <= nl_put_in;
      pend_addr_ff <= pend_addr_in;
      rd_zero_ff   <= rd_zero_in;
      if (emit) begin
         rsp_data_ff <= emit_data;
         rsp_col_ff  <= col_in;
         rsp_row_ff  <= row_in;
      end
   end

   // screen memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we)
         mem[mem_waddr] <= mem_wdata;
      if (rd_en)
         rd_data_ff <= mem[rd_addr];
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.cell_data  = rsp_data_ff;
   assign rsp_ch.column_now = rsp_col_ff;
   assign rsp_ch.row_now    = rsp_row_ff;

endmodule

[src/text_console_cell_writer_core.sv]
// ---------------------------------------------------------------------------
// text_console_cell_writer_core
// Text console with its own screen memory: prints characters, wraps, fills,
// scrolls, and reads back single cells.
// ---------------------------------------------------------------------------
// commands: a read returns one cell, a plain char or a tab writes cells at the
// cursor; a newline fills the rest of the row with spaces, and a scroll copies
// the rows up and blanks the last row; a full row wraps through a newline first
// the back end finishes one command before it takes the next;
// a stalled response word holds the next command in the two-entry queue
// reset: a clear pass zeroes all 2000 cells; requests wait, csr writes don't
module text_console_cell_writer_core (
   input  logic       clock,
   input  logic       reset,
   tccw_req_if.sink   req_ch,
   tccw_rsp_if.source rsp_ch,
   tccw_csr_if.sink   csr_ch
);
   import tccw_pkg::*;

   tccw_cfg_type cfg;
   tccw_cmd_type cmd;
   logic         cmd_valid;
   logic         cmd_pop;
   logic         clear_busy;

   tccw_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   tccw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .clear_busy (clear_busy),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   tccw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop),
      .clear_busy (clear_busy),
      .rsp_ch     (rsp_ch)
   );

endmodule
